// ----- hw/rtl/jvm_pkg.sv -----
// Shared types and constants for the joystick velocity mapper.
// No dependencies; imported by jvm_sqrt_pipe, jvm_div_pipe and the top level.
package jvm_pkg;

    // Radicand, root and quotient widths
    localparam int RAD_W = 32;
    localparam int ROOT_W = RAD_W / 2;
    localparam int NUM_W = 30;   // |axis| * limit < 2^30
    localparam int DEN_W = 16;

    // Register indexes
    localparam logic [2:0] REG_DEADZONE = 3'd0;
    localparam logic [2:0] REG_PAD_FS   = 3'd1;
    localparam logic [2:0] REG_KEY_LVL  = 3'd2;
    localparam logic [2:0] REG_RADIAL   = 3'd3;
    localparam logic [2:0] REG_ANGULAR  = 3'd4;
    localparam logic [2:0] REG_TORSO    = 3'd5;

    // Sideband that rides along with each transaction
    typedef struct packed {
        logic              sx;
        logic              sy;
        logic              sr;
        logic [NUM_W-1:0]  mx;
        logic [NUM_W-1:0]  my;
        logic [NUM_W-1:0]  mr;
        logic [15:0]       torso;
        logic              face;
        logic [DEN_W-1:0]  floor_val;
    } t_side;

endpackage

// ----- hw/rtl/jvm_sqrt_pipe.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on jvm_pkg.
module jvm_sqrt_pipe (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [jvm_pkg::RAD_W-1:0]   i_rad,
    input  jvm_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [jvm_pkg::ROOT_W-1:0]  o_root,
    output jvm_pkg::t_side              o_side
);
    import jvm_pkg::*;

    logic              r_v    [0:ROOT_W];
    logic [RAD_W-1:0]  r_rad  [0:ROOT_W];
    logic [ROOT_W+1:0] r_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] r_root [0:ROOT_W];
    t_side             r_side [0:ROOT_W];

    // Entry of the chain is the module input
    always_comb begin
        r_v[0]    = i_valid;
        r_rad[0]  = i_rad;
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_side[0] = i_side;
    end

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [ROOT_W+3:0] rem_sh;
        logic [ROOT_W+3:0] trial;
        logic              ge;

        // Bring down two radicand bits, try root*4+1
        always_comb begin
            rem_sh = {r_rem[g], r_rad[g][RAD_W-1 -: 2]};
            trial  = {2'b00, r_root[g], 2'b01};
            ge     = rem_sh >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rad[g+1]  <= {r_rad[g][RAD_W-3:0], 2'b00};
                r_rem[g+1]  <= ge ? (ROOT_W+2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
                r_root[g+1] <= {r_root[g][ROOT_W-2:0], ge};
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_valid = r_v[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_side  = r_side[ROOT_W];

endmodule

// ----- hw/rtl/jvm_div_pipe.sv -----
// Pipelined restoring divider, three numerators over one shared divisor.
// Depends on jvm_pkg.
module jvm_div_pipe (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_valid,
    input  logic [jvm_pkg::DEN_W-1:0]  i_den,
    input  jvm_pkg::t_side             i_side,
    output logic                       o_valid,
    output jvm_pkg::t_side             o_side   // mx/my/mr hold the quotients
);
    import jvm_pkg::*;

    logic              r_v    [0:NUM_W];
    logic [DEN_W-1:0]  r_den  [0:NUM_W];
    logic [DEN_W-1:0]  r_rem  [0:NUM_W][0:2];
    logic [NUM_W-1:0]  r_num  [0:NUM_W][0:2];
    logic [NUM_W-1:0]  r_quo  [0:NUM_W][0:2];
    t_side             r_side [0:NUM_W];

    always_comb begin
        r_v[0]      = i_valid;
        r_den[0]    = i_den;
        r_side[0]   = i_side;
        r_num[0][0] = i_side.mx;
        r_num[0][1] = i_side.my;
        r_num[0][2] = i_side.mr;
        for (int l = 0; l < 3; l++) begin
            r_rem[0][l] = '0;
            r_quo[0][l] = '0;
        end
    end

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_den[g+1]  <= r_den[g];
                r_side[g+1] <= r_side[g];
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [DEN_W:0] rem_sh;
            logic           ge;

            // Shift in the next numerator bit, subtract if it fits
            always_comb begin
                rem_sh = {r_rem[g][l], r_num[g][l][NUM_W-1]};
                ge     = rem_sh >= {1'b0, r_den[g]};
            end

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[g+1][l] <= ge ? DEN_W'(rem_sh - {1'b0, r_den[g]})
                                        : rem_sh[DEN_W-1:0];
                    r_num[g+1][l] <= {r_num[g][l][NUM_W-2:0], 1'b0};
                    r_quo[g+1][l] <= {r_quo[g][l][NUM_W-2:0], ge};
                end
            end
        end
    end

    always_comb begin
        o_side    = r_side[NUM_W];
        o_side.mx = r_quo[NUM_W][0];
        o_side.my = r_quo[NUM_W][1];
        o_side.mr = r_quo[NUM_W][2];
    end
    assign o_valid = r_v[NUM_W];

endmodule

// ----- hw/rtl/joystick_velocity_mapper.sv -----
// Top level: register file, input decode, products, root, divide, output stage.
// Depends on jvm_pkg, jvm_sqrt_pipe and jvm_div_pipe.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | i_valid / o_stall    | i_func, i_stick_x/y, i_trigger_*, buttons
//  output   | o_valid / i_stall    | o_vel_x/y/rot/torso, o_face
//  config   | APB psel/penable     | paddr[4:2] register, pwdata
//
// One transaction per cycle while no result waits. Stages: decode, multiply,
// add, 16 root stages, divisor select, 30 divide stages and the output
// register. The divide chain sets the depth. Synchronous active-low reset
// clears all valid bits and loads the register defaults. While a result
// waits under i_stall, the whole pipeline holds and o_stall is raised.
module joystick_velocity_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic signed [15:0] i_stick_x,
    input  logic signed [15:0] i_stick_y,
    input  logic [14:0] i_trigger_ccw,
    input  logic [14:0] i_trigger_cw,
    input  logic [2:0]  i_pad_buttons,
    input  logic [8:0]  i_key_bits,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_vel_x,
    output logic signed [15:0] o_vel_y,
    output logic signed [15:0] o_vel_rot,
    output logic signed [15:0] o_vel_torso,
    output logic        o_face
);
    import jvm_pkg::*;

    // Register file
    logic [14:0] r_deadzone, r_key_lvl, r_radial, r_angular, r_torso_lim;
    logic [15:0] r_pad_fs;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone  <= 15'd300;
            r_pad_fs    <= 16'd32769;
            r_key_lvl   <= 15'd1000;
            r_radial    <= 15'd4096;
            r_angular   <= 15'd4096;
            r_torso_lim <= 15'd4096;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_DEADZONE: r_deadzone  <= pwdata[14:0];
                REG_PAD_FS:   r_pad_fs    <= pwdata[15:0];
                REG_KEY_LVL:  r_key_lvl   <= pwdata[14:0];
                REG_RADIAL:   r_radial    <= pwdata[14:0];
                REG_ANGULAR:  r_angular   <= pwdata[14:0];
                REG_TORSO:    r_torso_lim <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_DEADZONE: prdata = {17'd0, r_deadzone};
            REG_PAD_FS:   prdata = {16'd0, r_pad_fs};
            REG_KEY_LVL:  prdata = {17'd0, r_key_lvl};
            REG_RADIAL:   prdata = {17'd0, r_radial};
            REG_ANGULAR:  prdata = {17'd0, r_angular};
            REG_TORSO:    prdata = {17'd0, r_torso_lim};
            default:      prdata = '0;
        endcase
    end

    // Global advance: everything holds while the output waits
    logic r_out_v;
    logic adv;
    assign adv     = !(r_out_v && i_stall);
    assign o_stall = !adv;

    // Stage A: decode to magnitude and sign per axis, clamp torso
    logic [15:0] n_ax, n_ay, n_ar;
    logic        n_sx, n_sy, n_sr;
    logic [15:0] n_torso;
    logic        n_face;
    logic [15:0] n_floor;
    logic [15:0] abs_sx, abs_sy;
    logic [15:0] t_mag;
    logic        t_neg;
    logic        kx_p, kx_n, ky_p, ky_n, kr_p, kr_n, kt_p, kt_n;

    always_comb begin
        abs_sx = i_stick_x[15] ? 16'(-i_stick_x) : i_stick_x;
        abs_sy = i_stick_y[15] ? 16'(-i_stick_y) : i_stick_y;
        kx_p = i_key_bits[1]; kx_n = i_key_bits[0];
        ky_p = i_key_bits[2]; ky_n = i_key_bits[3];
        kr_p = i_key_bits[4]; kr_n = i_key_bits[5];
        kt_p = i_key_bits[6]; kt_n = i_key_bits[7];
        if (!i_func) begin
            n_ax  = (abs_sx > {1'b0, r_deadzone}) ? abs_sx : 16'd0;
            n_sx  = i_stick_x[15];
            n_ay  = (abs_sy > {1'b0, r_deadzone}) ? abs_sy : 16'd0;
            n_sy  = !i_stick_y[15];   // Y is negated
            n_sr  = i_trigger_cw > i_trigger_ccw;
            n_ar  = n_sr ? {1'b0, i_trigger_cw - i_trigger_ccw}
                         : {1'b0, i_trigger_ccw - i_trigger_cw};
            t_mag = {15'd0, i_pad_buttons[0] ^ i_pad_buttons[1]};
            t_neg = i_pad_buttons[1] && !i_pad_buttons[0];
            n_face  = i_pad_buttons[2];
            n_floor = r_pad_fs;
        end else begin
            n_ax  = (kx_p ^ kx_n) ? {1'b0, r_key_lvl} : 16'd0;
            n_sx  = kx_n;
            n_ay  = (ky_p ^ ky_n) ? {1'b0, r_key_lvl} : 16'd0;
            n_sy  = ky_n;
            n_ar  = (kr_p ^ kr_n) ? {1'b0, r_key_lvl} : 16'd0;
            n_sr  = kr_n;
            t_mag = (kt_p ^ kt_n) ? {1'b0, r_key_lvl} : 16'd0;
            t_neg = kt_n && !kt_p;
            n_face  = i_key_bits[8];
            n_floor = {1'b0, r_key_lvl};
        end
        if (t_mag > {1'b0, r_torso_lim}) begin
            t_mag = {1'b0, r_torso_lim};
        end
        n_torso = t_neg ? 16'(-t_mag) : t_mag;
    end

    logic        r_a_v;
    logic [15:0] r_ax, r_ay, r_ar;
    logic        r_a_sx, r_a_sy, r_a_sr;
    logic [15:0] r_a_torso;
    logic        r_a_face;
    logic [15:0] r_a_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ax <= n_ax; r_ay <= n_ay; r_ar <= n_ar;
            r_a_sx <= n_sx; r_a_sy <= n_sy; r_a_sr <= n_sr;
            r_a_torso <= n_torso; r_a_face <= n_face; r_a_floor <= n_floor;
        end
    end

    // Stage B: squares and scaled numerators
    logic        r_b_v;
    logic [31:0] r_x2, r_y2;
    t_side       r_b_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (adv) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x2 <= r_ax * r_ax;
            r_y2 <= r_ay * r_ay;
            r_b_side.sx <= r_a_sx;
            r_b_side.sy <= r_a_sy;
            r_b_side.sr <= r_a_sr;
            r_b_side.mx <= NUM_W'(r_ax * r_radial);
            r_b_side.my <= NUM_W'(r_ay * r_radial);
            r_b_side.mr <= NUM_W'(r_ar * r_angular);
            r_b_side.torso <= r_a_torso;
            r_b_side.face <= r_a_face;
            r_b_side.floor_val <= r_a_floor;
        end
    end

    // Stage C: sum of squares
    logic             r_c_v;
    logic [RAD_W-1:0] r_rad;
    t_side            r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (adv) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rad    <= r_x2 + r_y2;
            r_c_side <= r_b_side;
        end
    end

    // Magnitude
    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    t_side             sq_side;

    jvm_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_c_v),
        .i_rad   (r_rad),
        .i_side  (r_c_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stage E: divisor = max(floor, magnitude), never zero
    logic             r_e_v;
    logic [DEN_W-1:0] r_den;
    t_side            r_e_side;
    logic [DEN_W-1:0] n_den;

    always_comb begin
        n_den = (sq_root > sq_side.floor_val) ? sq_root : sq_side.floor_val;
        if (n_den == '0) begin
            n_den = DEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (adv) begin
            r_e_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_den    <= n_den;
            r_e_side <= sq_side;
        end
    end

    // Quotients
    logic  dv_v;
    t_side dv_side;

    jvm_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_e_v),
        .i_den   (r_den),
        .i_side  (r_e_side),
        .o_valid (dv_v),
        .o_side  (dv_side)
    );

    // Output stage: apply sign, saturate to 16 bits
    function automatic logic [15:0] sat_sign(input logic neg, input logic [NUM_W-1:0] q);
        logic [15:0] res;
        if (!neg) begin
            res = (q > NUM_W'(32767)) ? 16'h7fff : q[15:0];
        end else begin
            res = (q > NUM_W'(32768)) ? 16'h8000 : 16'(-q[15:0]);
        end
        return res;
    endfunction

    logic [15:0] r_vx, r_vy, r_vr, r_vt;
    logic        r_face;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_vx   <= sat_sign(dv_side.sx, dv_side.mx);
            r_vy   <= sat_sign(dv_side.sy, dv_side.my);
            r_vr   <= sat_sign(dv_side.sr, dv_side.mr);
            r_vt   <= dv_side.torso;
            r_face <= dv_side.face;
        end
    end

    assign o_valid     = r_out_v;
    assign o_vel_x     = r_vx;
    assign o_vel_y     = r_vy;
    assign o_vel_rot   = r_vr;
    assign o_vel_torso = r_vt;
    assign o_face      = r_face;

    // Checks
    a_stall_only_on_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_vel_rot) && $stable(o_vel_x)))
        else $error("waiting result lost or changed");

    a_x_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_vel_x[15]) |-> (o_vel_x <= {1'b0, r_radial}))
        else $error("planar X exceeds radial limit");

endmodule
